### hdl/mbta_pkg.sv
package mbta_pkg;

  // Largest MBAP length accepted (unit id plus PDU)
  localparam int unsigned MaxAduLen = 254;

  // Byte positions within the MBAP header
  localparam logic [8:0] POS_TID_HI   = 9'd0;
  localparam logic [8:0] POS_TID_LO   = 9'd1;
  localparam logic [8:0] POS_LEN_HI   = 9'd4;
  localparam logic [8:0] POS_LEN_LO   = 9'd5;
  localparam logic [8:0] POS_UNIT_ID  = 9'd6;

  // Fixed characters of the ASCII frame
  localparam logic [6:0] CHAR_COLON = 7'h3A;
  localparam logic [6:0] CHAR_CR    = 7'h0D;
  localparam logic [6:0] CHAR_LF    = 7'h0A;
  localparam logic [6:0] CHAR_NONE  = 7'h00;

  // Character slot within the output sequence of one item
  typedef enum logic [2:0] {
    ST_COLON,
    ST_HI,
    ST_LO,
    ST_LRC_HI,
    ST_LRC_LO,
    ST_CR,
    ST_LF,
    ST_ERR
  } step_t;

  // Work handed from the parser to the character emitter for one item
  typedef struct packed {
    logic        err;     // bad length: one error result only
    logic        colon;   // unit id byte: lead with ':'
    logic        tail;    // last counted byte: append LRC, CR, LF
    logic [7:0]  data;    // byte to print as hex
    logic [7:0]  lrc;     // two's complement of the byte sum
    logic [15:0] tid;     // transaction id reported on every result
  } job_t;

  // Uppercase ASCII hex digit of a nibble
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] ch;
    if (nib <= 4'd9) begin
      ch = 7'h30 + {3'd0, nib};
    end else begin
      ch = 7'h41 + {3'd0, nib} - 7'd10;
    end
    return ch;
  endfunction

endpackage

### hdl/mbta_parse.sv
module mbta_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          frame_byte,
  output logic                job_load,
  output mbta_pkg::job_t      job
);

  logic [8:0]  pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] tid_r, tid_nxt;
  logic        len_bad;
  logic        last_byte;
  logic [8:0]  count;

  // Walk the header and the counted bytes of one frame
  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    tid_nxt   = tid_r;
    len_bad   = 1'b0;
    last_byte = 1'b0;
    count     = pos_r - 9'd5;
    job_load  = 1'b0;
    job       = '0;

    if (pos_r < mbta_pkg::POS_UNIT_ID) begin
      case (pos_r)
        mbta_pkg::POS_TID_HI: tid_nxt = {frame_byte, tid_r[7:0]};
        mbta_pkg::POS_TID_LO: tid_nxt = {tid_r[15:8], frame_byte};
        mbta_pkg::POS_LEN_HI: len_nxt = {frame_byte, len_r[7:0]};
        mbta_pkg::POS_LEN_LO: len_nxt = {len_r[15:8], frame_byte};
        default: ;
      endcase
      len_bad = (pos_r == mbta_pkg::POS_LEN_LO) &&
                ((len_nxt == 16'd0) || (len_nxt > 16'(mbta_pkg::MaxAduLen)));
      pos_nxt  = len_bad ? 9'd0 : pos_r + 9'd1;
      job_load = len_bad;
      job.err  = 1'b1;
      job.tid  = tid_nxt;
    end else begin
      // Counted byte: add to the sum, print as hex
      sum_nxt   = (pos_r == mbta_pkg::POS_UNIT_ID) ? frame_byte : sum_r + frame_byte;
      last_byte = {7'd0, count} >= len_r;
      pos_nxt   = last_byte ? 9'd0 : pos_r + 9'd1;
      job_load  = 1'b1;
      job.colon = (pos_r == mbta_pkg::POS_UNIT_ID);
      job.tail  = last_byte;
      job.data  = frame_byte;
      job.lrc   = 8'd0 - sum_nxt;
      job.tid   = tid_r;
    end

    if (!accept) begin
      pos_nxt  = pos_r;
      len_nxt  = len_r;
      sum_nxt  = sum_r;
      tid_nxt  = tid_r;
      job_load = 1'b0;
    end
  end

  // Hold frame state between items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
      sum_r <= '0;
      tid_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      sum_r <= sum_nxt;
      tid_r <= tid_nxt;
    end
  end

endmodule

### hdl/mbta_emit.sv
module mbta_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_load,
  input  mbta_pkg::job_t      job,
  output logic                job_free,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [6:0]          ascii_char,
  output logic                last_char,
  output logic [15:0]         transaction_id,
  output logic                length_error
);

  mbta_pkg::job_t  job_r;
  logic            job_vld_r;
  mbta_pkg::step_t step_r, step_nxt, step_start;
  logic            out_vld_r;
  logic [6:0]      char_r, char_nxt;
  logic            last_r, last_nxt;
  logic [15:0]     tid_r;
  logic            err_r;
  logic            load_out;
  logic            emit;
  logic            job_done;

  // Pick the character for the current slot and the slot after it
  always_comb begin
    step_nxt = step_r;
    char_nxt = mbta_pkg::CHAR_NONE;
    last_nxt = 1'b0;
    job_done = 1'b0;
    case (step_r)
      mbta_pkg::ST_COLON: begin
        char_nxt = mbta_pkg::CHAR_COLON;
        step_nxt = mbta_pkg::ST_HI;
      end
      mbta_pkg::ST_HI: begin
        char_nxt = mbta_pkg::hex_char(job_r.data[7:4]);
        step_nxt = mbta_pkg::ST_LO;
      end
      mbta_pkg::ST_LO: begin
        char_nxt = mbta_pkg::hex_char(job_r.data[3:0]);
        step_nxt = mbta_pkg::ST_LRC_HI;
        job_done = !job_r.tail;
      end
      mbta_pkg::ST_LRC_HI: begin
        char_nxt = mbta_pkg::hex_char(job_r.lrc[7:4]);
        step_nxt = mbta_pkg::ST_LRC_LO;
      end
      mbta_pkg::ST_LRC_LO: begin
        char_nxt = mbta_pkg::hex_char(job_r.lrc[3:0]);
        step_nxt = mbta_pkg::ST_CR;
      end
      mbta_pkg::ST_CR: begin
        char_nxt = mbta_pkg::CHAR_CR;
        step_nxt = mbta_pkg::ST_LF;
      end
      mbta_pkg::ST_LF: begin
        char_nxt = mbta_pkg::CHAR_LF;
        last_nxt = 1'b1;
        job_done = 1'b1;
      end
      mbta_pkg::ST_ERR: begin
        char_nxt = mbta_pkg::CHAR_NONE;
        last_nxt = 1'b1;
        job_done = 1'b1;
      end
      default: begin
        job_done = 1'b1;
      end
    endcase

    if (job.err) begin
      step_start = mbta_pkg::ST_ERR;
    end else if (job.colon) begin
      step_start = mbta_pkg::ST_COLON;
    end else begin
      step_start = mbta_pkg::ST_HI;
    end
  end

  assign load_out = !out_vld_r || out_tready;
  assign emit     = job_vld_r && load_out;
  assign job_free = !job_vld_r || (emit && job_done);

  // Advance through the characters of the held item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      step_r    <= mbta_pkg::ST_HI;
    end else if (job_load) begin
      job_vld_r <= 1'b1;
      step_r    <= step_start;
    end else if (emit) begin
      job_vld_r <= !job_done;
      step_r    <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_r <= char_nxt;
      last_r <= last_nxt;
      tid_r  <= job_r.tid;
      err_r  <= job_r.err;
    end
  end

  assign out_tvalid     = out_vld_r;
  assign ascii_char     = char_r;
  assign last_char      = last_r;
  assign transaction_id = tid_r;
  assign length_error   = err_r;

endmodule

### hdl/modbus_tcp_to_ascii_framer.sv
// Modbus TCP to Modbus ASCII framer. Feed the TCP frame one byte per item on
// the in_ channel (MBAP header first); the out_ channel gives the ASCII frame
// one character per item: ':' and two uppercase hex digits for the unit id,
// two hex digits for each following counted byte, then the LRC as two hex
// digits, CR and LF (out_tlast on the LF). Every character carries the
// transaction id of its frame. A length of zero or above 254 gives one error
// item (character 0, tlast and tuser set) on byte 5, and the next byte opens
// a new frame. Header bytes give no output. Counted bytes are limited by the
// output, one character per cycle while out_tready is high: two characters
// per byte, three for the unit id and four more for the closing LRC, CR and
// LF. An accepted byte is registered as the held item; its characters then
// pass through the output register. A held item's characters are buffered so
// the next byte is taken while the last character still waits at the output.
module modbus_tcp_to_ascii_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] frame_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [6:0] ascii_char, [22:7] transaction_id, [23] zero
  output logic        out_tlast,   // last_char
  output logic        out_tuser    // length_error
);

  logic           accept;
  logic           job_load;
  logic           job_free;
  mbta_pkg::job_t job;
  logic [6:0]     ascii_char;
  logic [15:0]    transaction_id;

  assign in_tready = job_free;
  assign accept    = in_tvalid && job_free;

  // Parse header, track sum and position
  mbta_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .frame_byte (in_tdata),
    .job_load   (job_load),
    .job        (job)
  );

  // Spell out each item as characters
  mbta_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_load       (job_load),
    .job            (job),
    .job_free       (job_free),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .ascii_char     (ascii_char),
    .last_char      (out_tlast),
    .transaction_id (transaction_id),
    .length_error   (out_tuser)
  );

  assign out_tdata = {1'b0, transaction_id, ascii_char};

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int RAND_ITEMS  = 370;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 20;
  localparam int HOLD_CYCLES = 400;

  // How a directed row is checked
  typedef enum logic [1:0] {
    CHK_NONE,   // header byte: no character due
    CHK_ERR,    // bad length: one error item with the typed transaction id
    CHK_MODEL   // characters worked out by the frame predictor
  } row_chk_t;

  typedef struct packed {
    logic [7:0]  b;
    row_chk_t    chk;
    logic [15:0] tid;
  } dir_row_t;

  // One character item of the ASCII frame
  typedef struct packed {
    logic [6:0]  ch;
    logic        last;
    logic [15:0] tid;
    logic        err;
  } ascii_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  // Framer state as the predictor sees it
  logic [8:0]  fr_pos;
  logic [15:0] fr_len;
  logic [7:0]  fr_sum;
  logic [15:0] fr_tid;

  ascii_item_t ascii_q[$];    // characters still due from the block
  ascii_item_t fresh_q[$];    // characters caused by the latest byte
  dir_row_t    dir_tab[$];

  int  n_sent;
  int  n_recv;
  int  n_bad;
  int  cycle_cnt;
  logic tx_burst;
  logic rx_burst;
  logic rx_hold;

  modbus_tcp_to_ascii_framer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Uppercase hex digit of a nibble
  function automatic logic [6:0] nib_ascii(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 7'h30 + {3'd0, nib};
    end
    return 7'h37 + {3'd0, nib};
  endfunction

  function automatic void push_char(input logic [6:0] ch, input logic last, input logic err);
    fresh_q.push_back('{ch, last, fr_tid, err});
  endfunction

  function automatic void push_hex(input logic [7:0] v);
    push_char(nib_ascii(v[7:4]), 1'b0, 1'b0);
    push_char(nib_ascii(v[3:0]), 1'b0, 1'b0);
  endfunction

  // Advance the framer state by one byte and collect the characters it causes
  function automatic void frame_to_ascii(input logic [7:0] b);
    logic [8:0] pos;
    logic [7:0] lrc;
    pos = fr_pos;
    fresh_q.delete();
    if (pos < mbta_pkg::POS_UNIT_ID) begin
      case (pos)
        mbta_pkg::POS_TID_HI: fr_tid[15:8] = b;
        mbta_pkg::POS_TID_LO: fr_tid[7:0]  = b;
        mbta_pkg::POS_LEN_HI: fr_len[15:8] = b;
        mbta_pkg::POS_LEN_LO: fr_len[7:0]  = b;
        default: ;
      endcase
      if (pos == mbta_pkg::POS_LEN_LO &&
          (fr_len == 16'd0 || fr_len > mbta_pkg::MaxAduLen)) begin
        push_char(mbta_pkg::CHAR_NONE, 1'b1, 1'b1);
        fr_pos = '0;
      end else begin
        fr_pos = pos + 9'd1;
      end
    end else begin
      // open the frame on the unit id
      if (pos == mbta_pkg::POS_UNIT_ID) begin
        fr_sum = 8'd0;
        push_char(mbta_pkg::CHAR_COLON, 1'b0, 1'b0);
      end
      fr_sum = fr_sum + b;
      push_hex(b);
      // close the frame after the last counted byte
      if (int'(pos) - int'(mbta_pkg::POS_UNIT_ID) + 1 >= int'(fr_len)) begin
        lrc = 8'd0 - fr_sum;
        push_hex(lrc);
        push_char(mbta_pkg::CHAR_CR, 1'b0, 1'b0);
        push_char(mbta_pkg::CHAR_LF, 1'b1, 1'b0);
        fr_pos = '0;
      end else begin
        fr_pos = pos + 9'd1;
      end
    end
  endfunction

  // Cycles to wait before the next item; flip between bursts and gaps now and then
  function automatic int draw_gap(inout logic burst);
    if ($urandom_range(0, 15) == 0) begin
      burst = ~burst;
    end
    return burst ? 0 : int'($urandom_range(0, 18));
  endfunction

  // Offer one byte, wait for the handshake, then queue its characters.
  // Entered and left at a falling edge; tvalid stays up for a back-to-back item.
  task automatic send_byte(input logic [7:0] b, input row_chk_t chk, input logic [15:0] tid);
    int gap;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    frame_to_ascii(b);
    case (chk)
      CHK_MODEL: foreach (fresh_q[i]) ascii_q.push_back(fresh_q[i]);
      CHK_ERR:   ascii_q.push_back('{mbta_pkg::CHAR_NONE, 1'b1, tid, 1'b1});
      default: ;
    endcase
    n_sent++;
    @(negedge clk);
  endtask

  // Drop tvalid and hold until every due character has come
  task automatic drain_tx();
    in_tvalid <= 1'b0;
    while (ascii_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Send one MBAP frame with random id and payload; bad lengths stop after byte 5
  task automatic send_frame(input logic [15:0] len);
    logic [15:0] tid;
    logic [15:0] proto;
    tid   = 16'($urandom);
    proto = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;
    send_byte(tid[15:8], CHK_MODEL, '0);
    send_byte(tid[7:0], CHK_MODEL, '0);
    send_byte(proto[15:8], CHK_MODEL, '0);
    send_byte(proto[7:0], CHK_MODEL, '0);
    send_byte(len[15:8], CHK_MODEL, '0);
    send_byte(len[7:0], CHK_MODEL, '0);
    if (len != 16'd0 && len <= mbta_pkg::MaxAduLen) begin
      repeat (len) send_byte(8'($urandom), CHK_MODEL, '0);
    end
  endtask

  // Receiver: check each character, then draw its stall
  initial begin : rx_proc
    int wait_left;
    ascii_item_t got;
    ascii_item_t want;
    wait_left  = 0;
    rx_burst   = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[6:0], out_tlast, out_tdata[22:7], out_tuser};
        n_recv++;
        if (ascii_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("%0t: character with none due: ch=%h last=%b tid=%h err=%b",
                     $realtime, got.ch, got.last, got.tid, got.err);
          end
        end else begin
          want = ascii_q.pop_front();
          if (got != want || out_tdata[23] !== 1'b0) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("%0t: mismatch: ch exp %h got %h, last exp %b got %b", $realtime,
                       want.ch, got.ch, want.last, got.last);
              $display("  tid exp %h got %h, err exp %b got %b, pad %b", want.tid, got.tid,
                       want.err, got.err, out_tdata[23]);
            end
          end
        end
        wait_left = draw_gap(rx_burst);
      end
      @(negedge clk);
      out_tready <= (wait_left == 0) && !rx_hold;
      if (wait_left > 0) begin
        wait_left--;
      end
    end
  end

  // Long receiver hold-off once the run is under way, so the input backs up
  initial begin : rx_hold_proc
    rx_hold = 1'b0;
    while (n_recv < 60) @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus: directed table, then random frames
  initial begin : tx_proc
    int n_frames;
    logic [15:0] len;
    n_sent    = 0;
    n_recv    = 0;
    n_bad     = 0;
    n_frames  = 0;
    tx_burst  = 1'b0;
    fr_pos    = '0;
    fr_len    = '0;
    fr_sum    = '0;
    fr_tid    = '0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;

    // zero length, all-ones transaction id
    dir_tab.push_back('{8'hFF, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'hFF, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h00, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h00, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h00, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h00, CHK_ERR,  16'hFFFF});
    // all-ones length, all-ones protocol id
    dir_tab.push_back('{8'h00, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h00, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'hFF, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'hFF, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'hFF, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'hFF, CHK_ERR,  16'h0000});
    // length one: unit id is also the last counted byte
    dir_tab.push_back('{8'h12, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h34, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h00, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h00, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h00, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h01, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'hFF, CHK_MODEL, 16'h0000});
    // length two with extreme payload bytes
    dir_tab.push_back('{8'hA5, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h5A, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h00, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h00, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h00, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h02, CHK_NONE, 16'h0000});
    dir_tab.push_back('{8'h00, CHK_MODEL, 16'h0000});
    dir_tab.push_back('{8'h80, CHK_MODEL, 16'h0000});

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].b, dir_tab[i].chk, dir_tab[i].tid);
    end
    drain_tx();

    // mostly well-formed frames, some bad lengths, one frame of the largest length
    while (n_sent < dir_tab.size() + RAND_ITEMS) begin
      if (n_frames == 6) begin
        send_frame(16'(mbta_pkg::MaxAduLen));
        drain_tx();
      end else begin
        case ($urandom_range(0, 11))
          0: len = 16'd0;
          1: len = $urandom_range(0, 1) ?
                   16'(mbta_pkg::MaxAduLen + 1) :
                   16'($urandom_range(mbta_pkg::MaxAduLen + 1, 16'hFFFF));
          2: len = 16'd1;
          default: len = 16'($urandom_range(2, 12));
        endcase
        send_frame(len);
      end
      n_frames++;
    end

    drain_tx();
    repeat (SETTLE) @(posedge clk);
    if (n_bad == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
